/* rtl/core/fmrsm_pkg.sv */
// shared types, codes and carrier table for the fm register shadow mute block
package fmrsm_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_MUTE  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  localparam logic [7:0] LEVEL_SEL_MASK = 8'he0;
  localparam logic [7:0] LEVEL_BASE     = 8'h60;
  localparam logic [7:0] ALG_SEL_MASK   = 8'hf8;
  localparam logic [7:0] ALG_BASE       = 8'h20;
  localparam logic [7:0] LEVEL_MAX      = 8'h7f;
  localparam logic [7:0] MUTE_ADD       = 8'd127;

  localparam int LEVEL_DEPTH = 32;
  localparam int ALG_DEPTH   = 8;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       mute_on;
  } req_t;

  typedef struct packed {
    logic [7:0] out_addr;
    logic [7:0] out_data;
    logic       chip_reset;
    logic       last;
  } rsp_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_MUTE  = 2'd1,
    CMD_RESET = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] addr;
    logic [7:0] data;
    logic       mute_on;
  } cmd_t;

  // bit n set: operator at offset ch + 8*n is a carrier
  function automatic logic [3:0] carrier_mask(input logic [2:0] alg);
    logic [3:0] m;
    case (alg)
      3'd4:    m = 4'h0c;
      3'd5:    m = 4'h0e;
      3'd6:    m = 4'h0e;
      3'd7:    m = 4'h0f;
      default: m = 4'h08;
    endcase
    return m;
  endfunction

endpackage

/* rtl/core/fmrsm_front.sv */
// request decode and two-entry command queue
module fmrsm_front (
  input  logic             clk,
  input  logic             rst,
  input  fmrsm_pkg::req_t  req,
  input  logic             push,
  output logic             full,
  output logic             cmd_valid,
  output fmrsm_pkg::cmd_t  cmd,
  input  logic             cmd_pop
);

  fmrsm_pkg::cmd_t q [fmrsm_pkg::QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       keep;
  logic       do_pop;
  fmrsm_pkg::cmd_t dec;

  assign full      = (count == 2'(fmrsm_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign accept    = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    dec.addr    = req.reg_addr;
    dec.data    = req.reg_data;
    dec.mute_on = req.mute_on;
    keep        = 1'b1;
    case (req.op)
      fmrsm_pkg::OP_WRITE: dec.kind = fmrsm_pkg::CMD_WRITE;
      fmrsm_pkg::OP_MUTE:  dec.kind = fmrsm_pkg::CMD_MUTE;
      fmrsm_pkg::OP_RESET: dec.kind = fmrsm_pkg::CMD_RESET;
      default: begin
        // unused op code is taken and dropped
        dec.kind = fmrsm_pkg::CMD_WRITE;
        keep     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept && keep) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(accept && keep) - 2'(do_pop);
    end
  end

endmodule

/* rtl/core/fmrsm_back.sv */
// shadow stores, carrier walk sequencer and result queue
module fmrsm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  fmrsm_pkg::cmd_t  cmd,
  output logic             cmd_pop,
  output fmrsm_pkg::rsp_t  rsp,
  output logic             empty,
  input  logic             pop
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [6:0] level_store [fmrsm_pkg::LEVEL_DEPTH];
  logic [2:0] alg_store   [fmrsm_pkg::ALG_DEPTH];
  logic [4:0] walk_pos;
  logic       walk_mute;

  fmrsm_pkg::rsp_t rq [fmrsm_pkg::QUEUE_DEPTH];
  logic       rq_wr;
  logic       rq_rd;
  logic [1:0] rq_count;
  logic       rq_space;
  logic       rq_push;
  logic       rq_pop;
  fmrsm_pkg::rsp_t rq_in;

  logic [2:0] walk_ch;
  logic [1:0] walk_slot;
  logic [4:0] walk_off;
  logic [3:0] walk_mask;
  logic       is_carrier;
  logic [7:0] lvl_sum;
  logic [7:0] lvl_out;
  logic       walk_step;
  logic       walk_done;
  logic       do_write;
  logic       do_reset;
  logic       lvl_hit;
  logic       alg_hit;

  assign rq_space = (rq_count != 2'(fmrsm_pkg::QUEUE_DEPTH));
  assign empty    = (rq_count == 2'd0);
  assign rsp      = rq[rq_rd];
  assign rq_pop   = pop && !empty;

  // walk order: channel outer, operator slot inner
  assign walk_ch    = walk_pos[4:2];
  assign walk_slot  = walk_pos[1:0];
  assign walk_off   = {walk_slot, walk_ch};
  assign walk_mask  = fmrsm_pkg::carrier_mask(alg_store[walk_ch]);
  assign is_carrier = walk_mask[walk_slot];
  assign lvl_sum    = {1'b0, level_store[walk_off]} + fmrsm_pkg::MUTE_ADD;
  assign walk_done  = (walk_pos == 5'h1f);

  always_comb begin
    if (walk_mute) begin
      lvl_out = (lvl_sum > fmrsm_pkg::LEVEL_MAX) ? fmrsm_pkg::LEVEL_MAX : lvl_sum;
    end else begin
      lvl_out = {1'b0, level_store[walk_off]};
    end
  end

  assign lvl_hit = ((cmd.addr & fmrsm_pkg::LEVEL_SEL_MASK) == fmrsm_pkg::LEVEL_BASE);
  assign alg_hit = ((cmd.addr & fmrsm_pkg::ALG_SEL_MASK) == fmrsm_pkg::ALG_BASE);

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    rq_push    = 1'b0;
    rq_in      = '0;
    walk_step  = 1'b0;
    do_write   = 1'b0;
    do_reset   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && rq_space) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            fmrsm_pkg::CMD_WRITE: begin
              rq_push        = 1'b1;
              rq_in.out_addr = cmd.addr;
              rq_in.out_data = cmd.data;
              rq_in.last     = 1'b1;
              do_write       = 1'b1;
            end
            fmrsm_pkg::CMD_RESET: begin
              rq_push          = 1'b1;
              rq_in.chip_reset = 1'b1;
              rq_in.last       = 1'b1;
              do_reset         = 1'b1;
            end
            default: begin
              state_next = ST_WALK;
            end
          endcase
        end
      end
      ST_WALK: begin
        rq_in.out_addr = fmrsm_pkg::LEVEL_BASE | {3'b000, walk_off};
        rq_in.out_data = lvl_out;
        // slot 3 is a carrier for every algorithm, so channel 7 slot 3 closes
        rq_in.last     = walk_done;
        if (!is_carrier || rq_space) begin
          walk_step = 1'b1;
          rq_push   = is_carrier;
          if (walk_done) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      walk_pos <= 5'd0;
    end else begin
      state <= state_next;
      if (walk_step) begin
        walk_pos <= walk_pos + 5'd1;
      end else if (state == ST_IDLE) begin
        walk_pos <= 5'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid && rq_space) begin
      walk_mute <= cmd.mute_on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || do_reset) begin
      for (int i = 0; i < fmrsm_pkg::LEVEL_DEPTH; i++) begin
        level_store[i] <= fmrsm_pkg::LEVEL_MAX[6:0];
      end
      for (int i = 0; i < fmrsm_pkg::ALG_DEPTH; i++) begin
        alg_store[i] <= 3'd0;
      end
    end else if (do_write) begin
      if (lvl_hit) begin
        level_store[cmd.addr[4:0]] <= cmd.data[6:0];
      end else if (alg_hit) begin
        alg_store[cmd.addr[2:0]] <= cmd.data[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq[rq_wr] <= rq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= 1'b0;
      rq_rd    <= 1'b0;
      rq_count <= 2'd0;
    end else begin
      if (rq_push) begin
        rq_wr <= ~rq_wr;
      end
      if (rq_pop) begin
        rq_rd <= ~rq_rd;
      end
      rq_count <= rq_count + 2'(rq_push) - 2'(rq_pop);
    end
  end

endmodule

/* rtl/core/fm_opm_register_shadow_mute.sv */
// Register shadow with carrier mute in front of an FM synthesizer register port.
// Requests enter a two-entry command queue and are carried out one at a time by
// the back end, whose results leave through a two-entry result queue. A register
// write or a reset gives one result. A mute request is picked up, and then the
// walk sequencer visits each of the 8 channels and 4 operator slots in turn, one
// per cycle, and emits a total-level write for each carrier (8 to 32 results),
// stretched only by a full result queue. Op code three is accepted and gives no
// result.
module fm_opm_register_shadow_mute (
  input  logic             clk,
  input  logic             rst,
  input  fmrsm_pkg::req_t  req,
  input  logic             push,
  output logic             full,
  output fmrsm_pkg::rsp_t  rsp,
  output logic             empty,
  input  logic             pop
);

  logic            cmd_valid;
  logic            cmd_pop;
  fmrsm_pkg::cmd_t cmd;

  fmrsm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .push      (push),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  fmrsm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

/* sim/fm_opm_register_shadow_mute_test.sv */
// testbench for the fm register shadow mute block: queue-side driving with scoreboard checking
`timescale 1ns / 1ps

module fm_opm_register_shadow_mute_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 50;
  localparam int DRAIN_CYCLES = 64;

  // shadow of the synthesizer levels and algorithms, plus the writes still owed
  class level_mute_scoreboard;
    bit [6:0] level_shadow[fmrsm_pkg::LEVEL_DEPTH];
    bit [2:0] alg_shadow[fmrsm_pkg::ALG_DEPTH];
    fmrsm_pkg::rsp_t owed_writes[$];
    int       errors;
    int       checked;

    function new();
      clear_shadows();
      errors = 0;
      checked = 0;
    endfunction

    function void clear_shadows();
      foreach (level_shadow[i]) level_shadow[i] = 7'h7f;
      foreach (alg_shadow[i]) alg_shadow[i] = 3'd0;
    endfunction

    function int pending();
      return owed_writes.size();
    endfunction

    function void note_request(fmrsm_pkg::req_t r);
      fmrsm_pkg::rsp_t w;
      bit [7:0] lvl;
      bit [8:0] sum;
      bit       carrier;
      int       off;
      w = '0;
      case (r.op)
        fmrsm_pkg::OP_WRITE: begin
          if ((r.reg_addr & fmrsm_pkg::LEVEL_SEL_MASK) == fmrsm_pkg::LEVEL_BASE)
            level_shadow[r.reg_addr[4:0]] = r.reg_data[6:0];
          else if ((r.reg_addr & fmrsm_pkg::ALG_SEL_MASK) == fmrsm_pkg::ALG_BASE)
            alg_shadow[r.reg_addr[2:0]] = r.reg_data[2:0];
          w.out_addr = r.reg_addr;
          w.out_data = r.reg_data;
          w.last = 1'b1;
          owed_writes.push_back(w);
        end
        fmrsm_pkg::OP_RESET: begin
          clear_shadows();
          w.chip_reset = 1'b1;
          w.last = 1'b1;
          owed_writes.push_back(w);
        end
        fmrsm_pkg::OP_MUTE: begin
          for (int ch = 0; ch < fmrsm_pkg::ALG_DEPTH; ch++) begin
            for (int slot = 0; slot < 4; slot++) begin
              // slot 3 is always a carrier, lower slots join as the algorithm rises
              case (slot)
                0: carrier = (alg_shadow[ch] == 3'd7);
                1: carrier = (alg_shadow[ch] >= 3'd5);
                2: carrier = (alg_shadow[ch] >= 3'd4);
                default: carrier = 1'b1;
              endcase
              if (carrier) begin
                off = ch + 8 * slot;
                lvl = {1'b0, level_shadow[off]};
                if (r.mute_on) begin
                  sum = lvl + fmrsm_pkg::MUTE_ADD;
                  lvl = (sum > fmrsm_pkg::LEVEL_MAX) ? fmrsm_pkg::LEVEL_MAX : sum[7:0];
                end
                w = '0;
                w.out_addr = fmrsm_pkg::LEVEL_BASE + 8'(off);
                w.out_data = lvl;
                owed_writes.push_back(w);
              end
            end
          end
          owed_writes[owed_writes.size() - 1].last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void check_result(fmrsm_pkg::rsp_t got);
      fmrsm_pkg::rsp_t want;
      if (owed_writes.size() == 0) begin
        $error("unexpected result: addr %0h data %0h chip_reset %0b last %0b",
               got.out_addr, got.out_data, got.chip_reset, got.last);
        errors++;
        return;
      end
      want = owed_writes.pop_front();
      checked++;
      if (got.out_addr !== want.out_addr) begin
        $error("out_addr: expected %0h, got %0h", want.out_addr, got.out_addr);
        errors++;
      end
      if (got.out_data !== want.out_data) begin
        $error("out_data: expected %0h, got %0h", want.out_data, got.out_data);
        errors++;
      end
      if (got.chip_reset !== want.chip_reset) begin
        $error("chip_reset: expected %0b, got %0b", want.chip_reset, got.chip_reset);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  fmrsm_pkg::req_t req;
  logic push;
  logic full;
  fmrsm_pkg::rsp_t rsp;
  logic empty;
  logic pop;

  level_mute_scoreboard sb;
  int send_idle;
  int recv_idle;
  int kind_count[4];

  fm_opm_register_shadow_mute uut (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .push  (push),
    .full  (full),
    .rsp   (rsp),
    .empty (empty),
    .pop   (pop)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    pop = !rst && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(rsp);
  end

  function automatic fmrsm_pkg::req_t make_req(logic [1:0] op, logic [7:0] addr,
                                               logic [7:0] data, logic mute);
    fmrsm_pkg::req_t r;
    r.op = op;
    r.reg_addr = addr;
    r.reg_data = data;
    r.mute_on = mute;
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(fmrsm_pkg::req_t r);
    while ($urandom_range(99) < send_idle) begin
      push = 1'b0;
      @(negedge clk);
    end
    req = r;
    push = 1'b1;
    do @(posedge clk); while (full);
    sb.note_request(r);
    kind_count[r.op]++;
    @(negedge clk);
  endtask

  function automatic fmrsm_pkg::req_t random_req();
    fmrsm_pkg::req_t r;
    int pick;
    r = make_req(2'($urandom_range(3)), 8'($urandom), 8'($urandom), 1'($urandom));
    pick = $urandom_range(99);
    if (pick < 55) begin
      r.op = fmrsm_pkg::OP_WRITE;
      pick = $urandom_range(99);
      if (pick < 40) r.reg_addr = fmrsm_pkg::LEVEL_BASE | 8'($urandom_range(31));
      else if (pick < 65) r.reg_addr = fmrsm_pkg::ALG_BASE | 8'($urandom_range(7));
    end else if (pick < 90) begin
      r.op = fmrsm_pkg::OP_MUTE;
    end else if (pick < 95) begin
      r.op = fmrsm_pkg::OP_RESET;
    end else begin
      r.op = OP_UNUSED;
    end
    return r;
  endfunction

  task automatic run_phase(int s_idle, int r_idle);
    int done;
    fmrsm_pkg::req_t r;
    send_idle = s_idle;
    recv_idle = r_idle;
    done = 0;
    while (done < PHASE_ITEMS) begin
      r = random_req();
      send_request(r);
      if (r.op != OP_UNUSED) done++;
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    req = '0;
    send_idle = 8;
    recv_idle = 85;
    foreach (kind_count[i]) kind_count[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // mute before any write: all channels on algorithm zero at full attenuation
    send_request(make_req(fmrsm_pkg::OP_MUTE, 8'h00, 8'h00, 1'b0));
    send_request(make_req(fmrsm_pkg::OP_WRITE, 8'h60, 8'h00, 1'b0));
    send_request(make_req(fmrsm_pkg::OP_WRITE, 8'h7f, 8'hff, 1'b1));
    send_request(make_req(fmrsm_pkg::OP_WRITE, 8'h67, 8'h80, 1'b0));
    send_request(make_req(fmrsm_pkg::OP_WRITE, 8'h5f, 8'h55, 1'b1));
    send_request(make_req(fmrsm_pkg::OP_WRITE, 8'h80, 8'haa, 1'b0));
    send_request(make_req(fmrsm_pkg::OP_WRITE, 8'h1f, 8'h01, 1'b0));
    send_request(make_req(fmrsm_pkg::OP_WRITE, 8'h28, 8'h07, 1'b1));
    send_request(make_req(fmrsm_pkg::OP_WRITE, 8'h00, 8'h00, 1'b0));
    send_request(make_req(fmrsm_pkg::OP_WRITE, 8'hff, 8'hff, 1'b1));
    // every algorithm on some channel, upper data bits set
    for (int ch = 0; ch < fmrsm_pkg::ALG_DEPTH; ch++)
      send_request(make_req(fmrsm_pkg::OP_WRITE, fmrsm_pkg::ALG_BASE | 8'(ch),
                            8'hf8 | 8'(7 - ch), 1'b0));
    send_request(make_req(fmrsm_pkg::OP_MUTE, 8'hff, 8'hff, 1'b1));
    send_request(make_req(fmrsm_pkg::OP_MUTE, 8'h00, 8'h00, 1'b0));
    send_request(make_req(OP_UNUSED, 8'hff, 8'hff, 1'b1));
    send_request(make_req(fmrsm_pkg::OP_RESET, 8'hff, 8'hff, 1'b1));
    send_request(make_req(fmrsm_pkg::OP_MUTE, 8'h00, 8'h00, 1'b0));

    run_phase(8, 85);
    run_phase(85, 8);
    run_phase(0, 0);
    push = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d writes, %0d mute requests, %0d resets, %0d unused-op requests",
             kind_count[fmrsm_pkg::OP_WRITE], kind_count[fmrsm_pkg::OP_MUTE],
             kind_count[fmrsm_pkg::OP_RESET], kind_count[OP_UNUSED]);
    $display("checked %0d results under sender and receiver stalls", sb.checked);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/fmrsm_pkg.sv
rtl/core/fmrsm_front.sv
rtl/core/fmrsm_back.sv
rtl/core/fm_opm_register_shadow_mute.sv
sim/fm_opm_register_shadow_mute_test.sv
